// ----- src/hhv_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hhv_pkg
// shared types and byte constants for the host header validator
// ----------------------------------------------------------------------------
package hhv_pkg;

  // default longest accepted value, in bytes
  localparam int MAX_HOST_LEN_DEF = 1024;

  // width of the reported host length
  localparam int LEN_W = 11;

  // bytes that steer the scan
  localparam logic [7:0] CH_DOT       = 8'h2E;
  localparam logic [7:0] CH_COLON     = 8'h3A;
  localparam logic [7:0] CH_LBRACKET  = 8'h5B;
  localparam logic [7:0] CH_RBRACKET  = 8'h5D;
  localparam logic [7:0] CH_NUL       = 8'h00;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_UPPER_A   = 8'h41;
  localparam logic [7:0] CH_UPPER_Z   = 8'h5A;
  localparam logic [7:0] CASE_OFFSET  = 8'h20;

  // parse mode of the current value
  typedef enum logic [1:0] {
    MODE_PLAIN,
    MODE_LITERAL,
    MODE_REST
  } mode_t;

  // one input byte
  typedef struct packed {
    logic [7:0] host_byte;
    logic       is_last;
    logic       no_byte;
  } item_t;

  // one result
  typedef struct packed {
    logic [7:0]       lower_byte;
    logic             done_res;
    logic             verdict;
    logic [LEN_W-1:0] host_length;
    logic             had_upper;
  } result_t;

endpackage : hhv_pkg
`default_nettype wire

// ----- src/hhv_scan.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hhv_scan
// per-value scan state and the combinational byte update with verdict
// ----------------------------------------------------------------------------
module hhv_scan #(
  parameter int MAX_HOST_LEN = hhv_pkg::MAX_HOST_LEN_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            step_en,
  input  wire hhv_pkg::item_t  item,
  input  wire logic            bs_sep,
  output hhv_pkg::result_t     res
);

  localparam int POS_W = $clog2(MAX_HOST_LEN + 1);
  localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_HOST_LEN);

  hhv_pkg::mode_t   mode_r, mode_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [POS_W-1:0] ldot_r, ldot_nxt;
  logic             dot_r, dot_nxt;
  logic [POS_W-1:0] hend_r, hend_nxt;
  logic             hend_set_r, hend_set_nxt;
  logic             rej_r, rej_nxt;
  logic             upper_r, upper_nxt;

  // scan results before the end-of-value clear
  hhv_pkg::mode_t   mode_s;
  logic [POS_W-1:0] pos_s, ldot_s, hend_s;
  logic             dot_s, hend_set_s, rej_s, upper_s;

  logic             is_upper;
  logic             bump;
  logic [POS_W-1:0] len_raw, len_trim;
  logic             rejected;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= hhv_pkg::MODE_PLAIN;
      pos_r      <= '0;
      ldot_r     <= '0;
      dot_r      <= 1'b0;
      hend_r     <= '0;
      hend_set_r <= 1'b0;
      rej_r      <= 1'b0;
      upper_r    <= 1'b0;
    end else if (step_en) begin
      mode_r     <= mode_nxt;
      pos_r      <= pos_nxt;
      ldot_r     <= ldot_nxt;
      dot_r      <= dot_nxt;
      hend_r     <= hend_nxt;
      hend_set_r <= hend_set_nxt;
      rej_r      <= rej_nxt;
      upper_r    <= upper_nxt;
    end
  end

  always_comb begin
    is_upper   = (item.host_byte >= hhv_pkg::CH_UPPER_A) &&
                 (item.host_byte <= hhv_pkg::CH_UPPER_Z);
    mode_s     = mode_r;
    pos_s      = pos_r;
    ldot_s     = ldot_r;
    dot_s      = dot_r;
    hend_s     = hend_r;
    hend_set_s = hend_set_r;
    rej_s      = rej_r;
    upper_s    = upper_r;
    bump       = 1'b0;

    if (!item.no_byte && !rej_r) begin
      if (pos_r >= MAX_POS) begin
        rej_s = 1'b1;
      end else begin
        bump = 1'b1;
        case (item.host_byte)
          hhv_pkg::CH_DOT: begin
            if (dot_r && (pos_r != '0) && (ldot_r == pos_r - 1'b1)) begin
              rej_s = 1'b1;
              bump  = 1'b0;
            end else begin
              ldot_s = pos_r;
              dot_s  = 1'b1;
            end
          end
          hhv_pkg::CH_COLON: begin
            if (mode_r == hhv_pkg::MODE_PLAIN) begin
              hend_s     = pos_r;
              hend_set_s = 1'b1;
              mode_s     = hhv_pkg::MODE_REST;
            end
          end
          hhv_pkg::CH_LBRACKET: begin
            if (pos_r == '0) begin
              mode_s = hhv_pkg::MODE_LITERAL;
            end
          end
          hhv_pkg::CH_RBRACKET: begin
            if (mode_r == hhv_pkg::MODE_LITERAL) begin
              hend_s     = pos_r + 1'b1;
              hend_set_s = 1'b1;
              mode_s     = hhv_pkg::MODE_REST;
            end
          end
          hhv_pkg::CH_NUL: begin
            rej_s = 1'b1;
            bump  = 1'b0;
          end
          default: begin
            if ((item.host_byte == hhv_pkg::CH_SLASH) ||
                (bs_sep && (item.host_byte == hhv_pkg::CH_BACKSLASH))) begin
              rej_s = 1'b1;
              bump  = 1'b0;
            end else if (is_upper) begin
              upper_s = 1'b1;
            end
          end
        endcase
        if (bump) begin
          pos_s = pos_r + 1'b1;
        end
      end
    end

    // host length with one trailing dot trimmed
    len_raw  = hend_set_s ? hend_s : pos_s;
    len_trim = len_raw;
    if (dot_s && (len_raw != '0) && (ldot_s == len_raw - 1'b1)) begin
      len_trim = len_raw - 1'b1;
    end
    rejected = rej_s || (len_trim == '0);

    res.lower_byte  = item.no_byte ? 8'h00 :
                      (is_upper ? item.host_byte + hhv_pkg::CASE_OFFSET : item.host_byte);
    res.done_res    = item.is_last;
    res.verdict     = item.is_last && rejected;
    res.host_length = (item.is_last && !rejected) ? hhv_pkg::LEN_W'(len_trim) : '0;
    res.had_upper   = item.is_last && !rejected && upper_s;

    if (item.is_last) begin
      mode_nxt     = hhv_pkg::MODE_PLAIN;
      pos_nxt      = '0;
      ldot_nxt     = '0;
      dot_nxt      = 1'b0;
      hend_nxt     = '0;
      hend_set_nxt = 1'b0;
      rej_nxt      = 1'b0;
      upper_nxt    = 1'b0;
    end else begin
      mode_nxt     = mode_s;
      pos_nxt      = pos_s;
      ldot_nxt     = ldot_s;
      dot_nxt      = dot_s;
      hend_nxt     = hend_s;
      hend_set_nxt = hend_set_s;
      rej_nxt      = rej_s;
      upper_nxt    = upper_s;
    end
  end

`ifndef SYNTHESIS
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= MAX_POS)
    else $error("position ran past the length limit");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && item.is_last |=> (pos_r == '0) && !rej_r && !hend_set_r &&
      (mode_r == hhv_pkg::MODE_PLAIN))
    else $error("scan state not cleared after last byte");

  a_reject_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    rej_r && step_en && !item.is_last |=> rej_r && $stable(pos_r))
    else $error("rejected value changed scan state");

  a_hend_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    hend_set_r |-> (hend_r <= pos_r) && (mode_r == hhv_pkg::MODE_REST))
    else $error("host end inconsistent with position or mode");
`endif

endmodule : hhv_scan
`default_nettype wire

// ----- src/host_header_validator.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// host_header_validator
// byte-serial host header check with lowercasing, port strip and verdict
// ----------------------------------------------------------------------------
//
//  channel  | direction | transfers
//  ---------+-----------+-------------------------------------------------
//  in_*     | slave     | one raw byte per transaction, tlast ends a value
//  out_*    | master    | one lowercased byte per transaction, verdict on tlast
//  cfg_*    | apb slave | backslash_is_separator at byte address 0
//
//  one byte per cycle sustained while out_tready stays high; a result passes
//  through the input register, then the result register
//  the scan state is updated in the same cycle a byte moves from the input
//  register into the result register, so the scan never makes consecutive bytes wait
//  out_tready low holds the result register and, in the same cycle, the input
//  register; in_tready drops only when both are full
//  rst_n is synchronous: it empties both registers, clears the scan state
//  and sets backslash_is_separator to 0
//
module host_header_validator #(
  parameter int MAX_HOST_LEN = hhv_pkg::MAX_HOST_LEN_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,

  // input byte stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,    // [7:0] host_byte
  input  wire logic        in_tlast,    // is_last
  input  wire logic        in_tuser,    // no_byte

  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,   // [7:0] lower_byte, [8] verdict,
                                        // [19:9] host_length, [20] had_upper,
                                        // [23:21] zero
  output logic             out_tlast,   // done_res

  // configuration port
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  // register index 0 sits where address bit 2 is clear
  localparam logic REG_BACKSLASH = 1'b0;

  logic             bs_sep_r;
  logic             cfg_hit;

  logic             s1_vld_r, s1_vld_nxt;
  hhv_pkg::item_t   s1_item_r;
  logic             out_vld_r, out_vld_nxt;
  hhv_pkg::result_t out_res_r;
  hhv_pkg::result_t scan_res;

  logic             advance;
  logic             in_accept;
  logic             step_en;

  // ---- configuration --------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_hit    = (cfg_paddr[2] == REG_BACKSLASH);
  assign cfg_prdata = cfg_hit ? {31'b0, bs_sep_r} : 32'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bs_sep_r <= 1'b0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_hit) begin
      bs_sep_r <= cfg_pwdata[0];
    end
  end

  // ---- handshake ------------------------------------------------------------
  // the result register can take a new entry when empty or being drained
  assign advance   = !out_vld_r || out_tready;
  assign in_tready = !s1_vld_r || advance;
  assign in_accept = in_tvalid && in_tready;
  // a byte is scanned exactly when it moves into the result register
  assign step_en   = s1_vld_r && advance;

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (in_accept) begin
      s1_vld_nxt = 1'b1;
    end else if (advance) begin
      s1_vld_nxt = 1'b0;
    end
    out_vld_nxt = advance ? s1_vld_r : out_vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // input register payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item_r.host_byte <= in_tdata;
      s1_item_r.is_last   <= in_tlast;
      s1_item_r.no_byte   <= in_tuser;
    end
  end

  // ---- scan -----------------------------------------------------------------
  hhv_scan #(
    .MAX_HOST_LEN (MAX_HOST_LEN)
  ) u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .item    (s1_item_r),
    .bs_sep  (bs_sep_r),
    .res     (scan_res)
  );

  // result register payload
  always_ff @(posedge clk) begin
    if (step_en) begin
      out_res_r <= scan_res;
    end
  end

  // ---- outputs --------------------------------------------------------------
  assign out_tvalid = out_vld_r;
  assign out_tlast  = out_res_r.done_res;
  assign out_tdata  = {3'b000, out_res_r.had_upper, out_res_r.host_length,
                       out_res_r.verdict, out_res_r.lower_byte};

`ifndef SYNTHESIS
  a_reject_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_res_r.verdict |->
      (out_res_r.host_length == '0) && !out_res_r.had_upper && out_res_r.done_res)
    else $error("rejected result carries length or case flag");

  a_mid_value_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_res_r.done_res |->
      !out_res_r.verdict && (out_res_r.host_length == '0) && !out_res_r.had_upper)
    else $error("verdict fields set before last byte");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && !advance |=> s1_vld_r && $stable(s1_item_r))
    else $error("input register overwritten while result stalled");
`endif

endmodule : host_header_validator
`default_nettype wire
